### sv/rtsd_pkg.sv
// Shared types, codes and helper functions for the relocation table stream decoder.
// Used by the parser, the result queue and the top level. No dependencies.
package rtsd_pkg;

   // Parse phases.
   localparam logic [3:0] PH_FORMAT  = 4'd0;
   localparam logic [3:0] PH_VERSION = 4'd1;
   localparam logic [3:0] PH_NAMELEN = 4'd2;
   localparam logic [3:0] PH_SKIP    = 4'd3;
   localparam logic [3:0] PH_PTRCNT  = 4'd4;
   localparam logic [3:0] PH_TYPE    = 4'd5;
   localparam logic [3:0] PH_ID      = 4'd6;
   localparam logic [3:0] PH_OFF     = 4'd7;
   localparam logic [3:0] PH_DONE    = 4'd8;

   // Result kinds.
   localparam logic [1:0] KIND_ENTRY  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Error codes.
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TRUNC     = 4'd1;
   localparam logic [3:0] ERR_FORMAT    = 4'd2;
   localparam logic [3:0] ERR_VERSION   = 4'd3;
   localparam logic [3:0] ERR_NAMELEN   = 4'd4;
   localparam logic [3:0] ERR_PTRSIZE   = 4'd5;
   localparam logic [3:0] ERR_COUNT     = 4'd6;
   localparam logic [3:0] ERR_ENCODING  = 4'd7;
   localparam logic [3:0] ERR_OVERFLOW  = 4'd8;
   localparam logic [3:0] ERR_OUTSIDE   = 4'd9;
   localparam logic [3:0] ERR_TRAILING  = 4'd10;
   localparam logic [3:0] ERR_MODSIZE   = 4'd11;

   // Configuration register indexes.
   localparam logic [2:0] REG_FILE_LENGTH  = 3'd0;
   localparam logic [2:0] REG_MODULE_SIZE  = 3'd1;
   localparam logic [2:0] REG_EXPECT_MAJOR = 3'd2;
   localparam logic [2:0] REG_EXPECT_MINOR = 3'd3;
   localparam logic [2:0] REG_EXPECT_PATCH = 3'd4;
   localparam logic [2:0] REG_EXPECT_BUILD = 3'd5;

   // Value encodings.
   localparam logic [2:0] ENC_FULL    = 3'd0;
   localparam logic [2:0] ENC_PLUS1   = 3'd1;
   localparam logic [2:0] ENC_ADD8    = 3'd2;
   localparam logic [2:0] ENC_SUB8    = 3'd3;
   localparam logic [2:0] ENC_ADD16   = 3'd4;
   localparam logic [2:0] ENC_SUB16   = 3'd5;
   localparam logic [2:0] ENC_ABS16   = 3'd6;
   localparam logic [2:0] ENC_ABS32   = 3'd7;

   localparam int unsigned FIFO_DEPTH = 4;

   typedef struct packed {
      logic [31:0] file_length;
      logic [63:0] module_size;
      logic [3:0][31:0] expect_word;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] entry_id;
      logic [63:0] entry_offset;
      logic [3:0]  error_code;
      logic        last;
   } result_type;

   // Number of payload bytes that follow for an encoding.
   function automatic logic [4:0] enc_size(input logic [2:0] enc);
      logic [4:0] s;
      case (enc) inside
         ENC_FULL:                    s = 5'd8;
         ENC_PLUS1:                   s = 5'd0;
         ENC_ADD8, ENC_SUB8:          s = 5'd1;
         ENC_ADD16, ENC_SUB16, ENC_ABS16: s = 5'd2;
         default:                     s = 5'd4;
      endcase
      return s;
   endfunction

   // Decodes a value against its predecessor; the top bit is set when no overflow.
   function automatic logic [64:0] decode(input logic [2:0] mode, input logic [63:0] prev,
                                          input logic [63:0] raw);
      logic [64:0] s;
      logic [63:0] r;
      logic [64:0] res;
      r = raw;
      s = {1'b0, prev} + {1'b0, raw};
      case (mode) inside
         ENC_PLUS1: begin
            r = 64'd1;
            s = {1'b0, prev} + {1'b0, r};
            res = {~s[64], s[63:0]};
         end
         ENC_ADD8, ENC_ADD16: res = {~s[64], s[63:0]};
         ENC_SUB8, ENC_SUB16: res = {(r <= prev), prev - r};
         default:             res = {1'b1, r};
      endcase
      return res;
   endfunction

endpackage

### sv/rtsd_parser.sv
// Byte parser: holds the parse state and decodes one byte per step.
// Depends on rtsd_pkg for phases, codes and the decode helpers.
module rtsd_parser
   import rtsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  cfg_type    cfg,
   output logic       push0,
   output logic       push1,
   output result_type res0,
   output result_type res1
);

   logic [3:0]  phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [3:0]  fbi_ff, fbi_in;
   logic [63:0] aw_ff, aw_in;
   logic [7:0]  et_ff, et_in;
   logic [63:0] pend_ff, pend_in;
   logic [63:0] lid_ff, lid_in;
   logic [63:0] loff_ff, loff_in;
   logic [30:0] left_ff, left_in;
   logic [30:0] skip_ff, skip_in;
   logic [4:0]  rsize_ff, rsize_in;

   logic        fail;
   logic [3:0]  fail_code;
   logic        br;
   logic [3:0]  br_phase;
   logic [4:0]  br_size;
   logic        e_valid, acc;
   logic [63:0] e_id, e_off;
   logic [31:0] pos_n, rem;
   logic [3:0]  i;
   logic [5:0]  sh;
   logic [63:0] aw_n;
   logic [7:0]  et;
   logic        do_id, do_off;
   logic [63:0] id_raw, off_raw, off_id;
   logic [64:0] id_dec, off_dec;
   logic [63:0] base, off_val;
   logic [3:0]  oenc;
   logic [31:0] word;

   // Next-state logic for one byte.
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; fbi_in = fbi_ff; aw_in = aw_ff;
      et_in = et_ff; pend_in = pend_ff; lid_in = lid_ff; loff_in = loff_ff;
      left_in = left_ff; skip_in = skip_ff; rsize_in = rsize_ff;
      fail = 1'b0; fail_code = ERR_NONE; br = 1'b0; br_phase = PH_DONE; br_size = '0;
      e_valid = 1'b0; acc = 1'b0; e_id = '0; e_off = '0;
      do_id = 1'b0; do_off = 1'b0; id_raw = '0; off_raw = '0; off_id = pend_ff;
      id_dec = '0; off_dec = '0; base = '0; off_val = '0;
      pos_n = pos_ff + 32'd1;
      rem = (pos_n < cfg.file_length) ? cfg.file_length - pos_n : 32'd0;
      i = fbi_ff;
      sh = (phase_ff == PH_VERSION || phase_ff == PH_PTRCNT) ? {i[1:0], 3'b000}
                                                             : {i[2:0], 3'b000};
      aw_n = aw_ff | ({56'd0, data_byte} << sh);
      word = aw_n[31:0];
      et = (phase_ff == PH_TYPE) ? data_byte : et_ff;
      oenc = et[7:4];

      if (phase_ff != PH_DONE) begin
         // Checks made before the byte is consumed.
         if (phase_ff == PH_FORMAT && pos_ff == '0 && fbi_ff == '0) begin
            if (cfg.module_size == '0) begin
               fail = 1'b1; fail_code = ERR_MODSIZE;
            end else if (cfg.file_length < 32'd4) begin
               fail = 1'b1; fail_code = ERR_TRUNC;
            end
         end
         if (!fail && pos_ff >= cfg.file_length) begin
            fail = 1'b1; fail_code = ERR_TRUNC;
         end

         if (!fail) begin
            pos_in = pos_n;
            if (phase_ff == PH_SKIP) begin
               skip_in = skip_ff - 31'd1;
               if (skip_in == '0) begin
                  br = 1'b1; br_phase = PH_PTRCNT; br_size = 5'd8;
               end
            end else begin
               aw_in = aw_n;
               fbi_in = i + 4'd1;
               case (phase_ff)
                  PH_FORMAT: begin
                     if (i == 4'd3) begin
                        if (word != 32'd2) begin
                           fail = 1'b1; fail_code = ERR_FORMAT;
                        end else begin
                           pend_in = '0;
                           br = 1'b1; br_phase = PH_VERSION; br_size = 5'd16;
                        end
                     end
                  end
                  PH_VERSION: begin
                     if (i[1:0] == 2'd3) begin
                        if (word != cfg.expect_word[i[3:2]]) pend_in = 64'd1;
                        aw_in = '0;
                        if (i == 4'd15) begin
                           if (pend_in != '0) begin
                              fail = 1'b1; fail_code = ERR_VERSION;
                           end else begin
                              br = 1'b1; br_phase = PH_NAMELEN; br_size = 5'd4;
                           end
                        end
                     end
                  end
                  PH_NAMELEN: begin
                     if (i == 4'd3) begin
                        if (word[31] || rem < 32'd8 || word > rem - 32'd8) begin
                           fail = 1'b1; fail_code = ERR_NAMELEN;
                        end else if (word == '0) begin
                           br = 1'b1; br_phase = PH_PTRCNT; br_size = 5'd8;
                        end else begin
                           skip_in = word[30:0];
                           phase_in = PH_SKIP;
                        end
                     end
                  end
                  PH_PTRCNT: begin
                     if (i == 4'd3) begin
                        pend_in = {63'd0, (word == 32'd8)};
                        aw_in = '0;
                     end else if (i == 4'd7) begin
                        if (pend_ff == '0) begin
                           fail = 1'b1; fail_code = ERR_PTRSIZE;
                        end else if (word[31] || word == '0 || word > rem) begin
                           fail = 1'b1; fail_code = ERR_COUNT;
                        end else begin
                           left_in = word[30:0];
                           pend_in = '0;
                           br = 1'b1; br_phase = PH_TYPE; br_size = 5'd1;
                        end
                     end
                  end
                  PH_TYPE: begin
                     et_in = data_byte;
                     if (data_byte[3]) begin
                        fail = 1'b1; fail_code = ERR_ENCODING;
                     end else if (enc_size(data_byte[2:0]) == '0) begin
                        do_id = 1'b1;
                     end else begin
                        br = 1'b1; br_phase = PH_ID; br_size = enc_size(data_byte[2:0]);
                     end
                  end
                  PH_ID: begin
                     if ({1'b0, i} + 5'd1 >= rsize_ff) begin
                        do_id = 1'b1; id_raw = aw_n;
                     end
                  end
                  PH_OFF: begin
                     if ({1'b0, i} + 5'd1 >= rsize_ff) begin
                        do_off = 1'b1; off_raw = aw_n;
                     end
                  end
                  default: ;
               endcase
            end

            // Identifier completed.
            if (do_id) begin
               id_dec = decode(et[2:0], lid_ff, id_raw);
               if (!id_dec[64]) begin
                  fail = 1'b1; fail_code = ERR_OVERFLOW;
               end else begin
                  pend_in = id_dec[63:0];
                  if (oenc[3] && loff_ff[2:0] != 3'd0) begin
                     fail = 1'b1; fail_code = ERR_ENCODING;
                  end else if (enc_size(oenc[2:0]) == '0) begin
                     do_off = 1'b1; off_raw = '0; off_id = id_dec[63:0];
                  end else begin
                     br = 1'b1; br_phase = PH_OFF; br_size = enc_size(oenc[2:0]);
                  end
               end
            end

            // Offset completed: the entry is emitted here.
            if (do_off) begin
               base = oenc[3] ? (loff_ff >> 3) : loff_ff;
               off_dec = decode(oenc[2:0], base, off_raw);
               off_val = off_dec[63:0];
               if (!off_dec[64] || (oenc[3] && off_val[63:61] != 3'd0)) begin
                  fail = 1'b1; fail_code = ERR_OVERFLOW;
               end else begin
                  if (oenc[3]) off_val = off_val << 3;
                  if (off_val >= cfg.module_size) begin
                     fail = 1'b1; fail_code = ERR_OUTSIDE;
                  end else begin
                     e_valid = 1'b1; e_id = off_id; e_off = off_val;
                     lid_in = off_id; loff_in = off_val;
                     left_in = left_ff - 31'd1;
                     if (left_in == '0) begin
                        if (rem != '0) begin
                           fail = 1'b1; fail_code = ERR_TRAILING;
                        end else begin
                           acc = 1'b1; phase_in = PH_DONE;
                        end
                     end else begin
                        br = 1'b1; br_phase = PH_TYPE; br_size = 5'd1;
                     end
                  end
               end
            end

            // Start of the next field.
            if (br && !fail) begin
               if (rem < {27'd0, br_size}) begin
                  fail = 1'b1; fail_code = ERR_TRUNC;
               end else begin
                  phase_in = br_phase; rsize_in = br_size; fbi_in = '0; aw_in = '0;
               end
            end
         end
         if (fail) phase_in = PH_DONE;
      end
   end

   // Result slots.
   always_comb begin
      push0 = e_valid || fail || acc;
      push1 = e_valid && (fail || acc);
      res1.kind = fail ? KIND_REJECT : KIND_ACCEPT;
      res1.entry_id = '0;
      res1.entry_offset = '0;
      res1.error_code = fail ? fail_code : ERR_NONE;
      res1.last = 1'b1;
      if (e_valid) begin
         res0.kind = KIND_ENTRY;
         res0.entry_id = e_id;
         res0.entry_offset = e_off;
         res0.error_code = ERR_NONE;
         res0.last = !push1;
      end else begin
         res0 = res1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FORMAT; pos_ff <= '0; fbi_ff <= '0; aw_ff <= '0; et_ff <= '0;
         pend_ff <= '0; lid_ff <= '0; loff_ff <= '0; left_ff <= '0; skip_ff <= '0;
         rsize_ff <= 5'd4;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; fbi_ff <= fbi_in; aw_ff <= aw_in;
         et_ff <= et_in; pend_ff <= pend_in; lid_ff <= lid_in; loff_ff <= loff_in;
         left_ff <= left_in; skip_ff <= skip_in; rsize_ff <= rsize_in;
      end
   end

endmodule

### sv/rtsd_result_fifo.sv
// Small result queue that takes up to two results a cycle and hands out one.
// Depends on rtsd_pkg for the result record type.
module rtsd_result_fifo
   import rtsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push0,
   input  logic       push1,
   input  result_type din0,
   input  result_type din1,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type dout
);

   localparam int unsigned AW = $clog2(FIFO_DEPTH);

   result_type       mem_ff [FIFO_DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             pop;
   logic [AW-1:0]    wp1;

   assign out_valid = cnt_ff != '0;
   assign dout = mem_ff[rp_ff];
   assign pop = out_valid && out_ready;
   assign room = cnt_ff <= (AW + 1)'(FIFO_DEPTH - 2);
   assign wp1 = wp_ff + 1'b1;

   // Pointer and fill count update.
   always_comb begin
      wp_in = wp_ff + AW'({1'b0, push0} + {1'b0, push1});
      rp_in = rp_ff + AW'(pop);
      cnt_in = cnt_ff + (AW + 1)'(push0) + (AW + 1)'(push1) - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push0) mem_ff[wp_ff] <= din0;
      if (push1) mem_ff[wp1] <= din1;
   end

endmodule

### sv/relocation_table_stream_decoder.sv
// Top level of the relocation table stream decoder: input register, register
// file, parser and result queue. Depends on rtsd_pkg, rtsd_parser, rtsd_result_fifo.
//
// Usage: file bytes arrive in order on the req_ channel, one beat per byte.
// Each byte is taken into an input register and parsed from there once
// the result queue has room; every decoded entry, and the final accept or
// reject, appears on the rsp_ channel as a beat of its own, the last
// result of a byte marked by rsp_last. Throughput is one byte per cycle
// while the receiver keeps up; a byte that completes the last entry gives
// two results and the queue drains them one a cycle. Registers are written
// on the csr_ channel (always ready); the user must write them only while
// the block is idle, and the block has no check for this. Reset clears the
// parse state, empties the result queue and sets the file length to one
// and the other registers to zero. When the receiver stalls the four-entry
// result queue fills and req_ready falls until room for two results is
// free again. After the final result further bytes are taken and dropped.
module relocation_table_stream_decoder
   import rtsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [63:0] rsp_entry_id,
   output logic [63:0] rsp_entry_offset,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       room, step, push0, push1;
   result_type res0, res1, dout;

   assign csr_ready = 1'b1;
   assign step = in_valid_ff && room;
   assign req_ready = !in_valid_ff || step;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_length <= 32'd1;
         cfg_ff.module_size <= '0;
         cfg_ff.expect_word <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FILE_LENGTH:  cfg_ff.file_length <= csr_data[31:0];
            REG_MODULE_SIZE:  cfg_ff.module_size <= csr_data;
            REG_EXPECT_MAJOR: cfg_ff.expect_word[0] <= csr_data[31:0];
            REG_EXPECT_MINOR: cfg_ff.expect_word[1] <= csr_data[31:0];
            REG_EXPECT_PATCH: cfg_ff.expect_word[2] <= csr_data[31:0];
            REG_EXPECT_BUILD: cfg_ff.expect_word[3] <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_byte_ff <= req_data_byte;
   end

   rtsd_parser u_parser (
      .clock(clock), .reset(reset), .step(step), .data_byte(in_byte_ff), .cfg(cfg_ff),
      .push0(push0), .push1(push1), .res0(res0), .res1(res1)
   );

   rtsd_result_fifo u_fifo (
      .clock(clock), .reset(reset), .push0(push0 && step), .push1(push1 && step),
      .din0(res0), .din1(res1), .room(room), .out_valid(rsp_valid),
      .out_ready(rsp_ready), .dout(dout)
   );

   assign rsp_result_kind  = dout.kind;
   assign rsp_entry_id     = dout.entry_id;
   assign rsp_entry_offset = dout.entry_offset;
   assign rsp_error_code   = dout.error_code;
   assign rsp_last         = dout.last;

endmodule

### sv/rtsd_checker.sv
// Port-level checks on the relocation table stream decoder, bound to the top level.
// Depends on rtsd_pkg for result kinds and codes.
module rtsd_checker
   import rtsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_result_kind,
   input logic [3:0] rsp_error_code,
   input logic       rsp_last
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // Entries carry no error code.
   a_entry_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ENTRY |-> rsp_error_code == ERR_NONE)
      else $error("entry beat with an error code");

   // An accept is final and carries no error.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ACCEPT |-> rsp_last && rsp_error_code == ERR_NONE)
      else $error("malformed accept beat");

   // A rejection is final and names a cause.
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_REJECT |-> rsp_last && rsp_error_code != ERR_NONE)
      else $error("malformed reject beat");

endmodule

bind relocation_table_stream_decoder rtsd_checker u_rtsd_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_kind(rsp_result_kind), .rsp_error_code(rsp_error_code), .rsp_last(rsp_last)
);

### verif/relocation_table_stream_decoder_checker.sv
// Checker for the relocation table stream decoder: watches the csr_, req_ and rsp_
// channels, predicts every result beat and compares it. Depends on rtsd_pkg.
module relocation_table_stream_decoder_checker
   import rtsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_result_kind,
   input  logic [63:0] rsp_entry_id,
   input  logic [63:0] rsp_entry_offset,
   input  logic [3:0]  rsp_error_code,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   // Shadow registers.
   logic [31:0] cfg_file_length;
   logic [63:0] cfg_module_size;
   logic [31:0] cfg_version [4];

   // Shadow parse state.
   logic [3:0]  phase;
   logic [31:0] position;
   logic [3:0]  field_index;
   logic [63:0] gather;
   logic [7:0]  type_byte;
   logic [63:0] held_id;
   logic [63:0] prev_id;
   logic [63:0] prev_offset;
   logic [30:0] entries_todo;
   logic [30:0] skip_todo;
   int          read_bytes;

   result_type  expected_results [$];
   result_type  byte_results [$];

   assign pending_count = expected_results.size();

   function automatic void push_result(input logic [1:0] k, input logic [63:0] id,
                                       input logic [63:0] off, input logic [3:0] code);
      result_type r;
      r.kind = k;
      r.entry_id = id;
      r.entry_offset = off;
      r.error_code = code;
      r.last = 1'b0;
      byte_results = {byte_results, r};
   endfunction

   function automatic void reject(input logic [3:0] code);
      push_result(KIND_REJECT, 64'd0, 64'd0, code);
      phase = PH_DONE;
   endfunction

   function automatic logic [63:0] bytes_left();
      return (position < cfg_file_length) ? 64'(cfg_file_length - position) : 64'd0;
   endfunction

   function automatic void open_field(input logic [3:0] ph, input int size);
      if (bytes_left() < 64'(size)) begin
         reject(ERR_TRUNC);
      end else begin
         phase = ph;
         read_bytes = size;
         field_index = 4'd0;
         gather = 64'd0;
      end
   endfunction

   function automatic int payload_bytes(input logic [2:0] enc);
      case (enc)
         ENC_FULL:  return 8;
         ENC_PLUS1: return 0;
         ENC_ADD8, ENC_SUB8: return 1;
         ENC_ABS32: return 4;
         default:   return 2;
      endcase
   endfunction

   // Applies an encoding to the previous value; returns 0 on overflow.
   function automatic bit apply_encoding(input logic [2:0] enc, input logic [63:0] prev,
                                         input logic [63:0] raw, output logic [63:0] value);
      logic [63:0] delta;
      delta = (enc == ENC_PLUS1) ? 64'd1 : raw;
      value = raw;
      case (enc)
         ENC_PLUS1, ENC_ADD8, ENC_ADD16: begin
            if (delta > ~prev) return 1'b0;
            value = prev + delta;
         end
         ENC_SUB8, ENC_SUB16: begin
            if (delta > prev) return 1'b0;
            value = prev - delta;
         end
         default: value = raw;
      endcase
      return 1'b1;
   endfunction

   function automatic void finish_offset(input logic [63:0] raw);
      logic [3:0]  enc;
      logic [63:0] base;
      logic [63:0] off;
      enc = type_byte[7:4];
      base = enc[3] ? (prev_offset >> 3) : prev_offset;
      if (!apply_encoding(enc[2:0], base, raw, off)) begin
         reject(ERR_OVERFLOW);
      end else if (enc[3] && off > (64'hFFFF_FFFF_FFFF_FFFF >> 3)) begin
         reject(ERR_OVERFLOW);
      end else begin
         if (enc[3]) off = off << 3;
         if (off >= cfg_module_size) begin
            reject(ERR_OUTSIDE);
         end else begin
            push_result(KIND_ENTRY, held_id, off, ERR_NONE);
            prev_id = held_id;
            prev_offset = off;
            entries_todo = entries_todo - 31'd1;
            if (entries_todo == 31'd0) begin
               if (bytes_left() != 64'd0) begin
                  reject(ERR_TRAILING);
               end else begin
                  push_result(KIND_ACCEPT, 64'd0, 64'd0, ERR_NONE);
                  phase = PH_DONE;
               end
            end else begin
               open_field(PH_TYPE, 1);
            end
         end
      end
   endfunction

   function automatic void finish_id(input logic [63:0] raw);
      logic [63:0] id;
      logic [3:0]  enc;
      if (!apply_encoding(type_byte[2:0], prev_id, raw, id)) begin
         reject(ERR_OVERFLOW);
      end else begin
         held_id = id;
         enc = type_byte[7:4];
         if (enc[3] && prev_offset[2:0] != 3'd0) reject(ERR_ENCODING);
         else if (payload_bytes(enc[2:0]) == 0) finish_offset(64'd0);
         else open_field(PH_OFF, payload_bytes(enc[2:0]));
      end
   endfunction

   // Works out the results caused by one accepted byte.
   function automatic void predict_byte(input logic [7:0] b);
      logic [3:0]  i;
      int          sh;
      logic [31:0] word;
      result_type  r;
      byte_results.delete();
      if (phase >= PH_DONE) return;
      if (phase == PH_FORMAT && position == 32'd0 && field_index == 4'd0) begin
         if (cfg_module_size == 64'd0) reject(ERR_MODSIZE);
         else if (cfg_file_length < 32'd4) reject(ERR_TRUNC);
      end
      if (phase != PH_DONE && position >= cfg_file_length) reject(ERR_TRUNC);
      if (phase != PH_DONE) begin
         position = position + 32'd1;
         if (phase == PH_SKIP) begin
            skip_todo = skip_todo - 31'd1;
            if (skip_todo == 31'd0) open_field(PH_PTRCNT, 8);
         end else begin
            i = field_index;
            sh = (phase == PH_VERSION || phase == PH_PTRCNT) ? 8 * i[1:0] : 8 * i[2:0];
            gather = gather | (64'(b) << sh);
            field_index = i + 4'd1;
            word = gather[31:0];
            case (phase)
               PH_FORMAT: begin
                  if (i == 4'd3) begin
                     if (word != 32'd2) reject(ERR_FORMAT);
                     else begin
                        held_id = 64'd0;
                        open_field(PH_VERSION, 16);
                     end
                  end
               end
               PH_VERSION: begin
                  if (i[1:0] == 2'd3) begin
                     if (word != cfg_version[i[3:2]]) held_id = 64'd1;
                     gather = 64'd0;
                     if (i == 4'd15) begin
                        if (held_id != 64'd0) reject(ERR_VERSION);
                        else open_field(PH_NAMELEN, 4);
                     end
                  end
               end
               PH_NAMELEN: begin
                  if (i == 4'd3) begin
                     if (word[31] || bytes_left() < 64'd8 || 64'(word) > bytes_left() - 64'd8)
                        reject(ERR_NAMELEN);
                     else if (word == 32'd0) open_field(PH_PTRCNT, 8);
                     else begin
                        skip_todo = word[30:0];
                        phase = PH_SKIP;
                     end
                  end
               end
               PH_PTRCNT: begin
                  if (i == 4'd3) begin
                     held_id = (word == 32'd8) ? 64'd1 : 64'd0;
                     gather = 64'd0;
                  end else if (i == 4'd7) begin
                     if (held_id == 64'd0) reject(ERR_PTRSIZE);
                     else if (word[31] || word == 32'd0 || 64'(word) > bytes_left())
                        reject(ERR_COUNT);
                     else begin
                        entries_todo = word[30:0];
                        held_id = 64'd0;
                        open_field(PH_TYPE, 1);
                     end
                  end
               end
               PH_TYPE: begin
                  type_byte = b;
                  if (b[3]) reject(ERR_ENCODING);
                  else if (payload_bytes(b[2:0]) == 0) finish_id(64'd0);
                  else open_field(PH_ID, payload_bytes(b[2:0]));
               end
               PH_ID: if (int'(i) + 1 >= read_bytes) finish_id(gather);
               PH_OFF: if (int'(i) + 1 >= read_bytes) finish_offset(gather);
               default: ;
            endcase
         end
      end
      if (byte_results.size() > 0) begin
         r = byte_results[byte_results.size() - 1];
         r.last = 1'b1;
         byte_results[byte_results.size() - 1] = r;
      end
      foreach (byte_results[k]) expected_results = {expected_results, byte_results[k]};
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Compare the result beat first, then take the configuration and byte beats.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fail_count = 0;
         cfg_file_length = 32'd1;
         cfg_module_size = 64'd0;
         foreach (cfg_version[k]) cfg_version[k] = 32'd0;
         phase = PH_FORMAT;
         position = 32'd0;
         field_index = 4'd0;
         gather = 64'd0;
         type_byte = 8'd0;
         held_id = 64'd0;
         prev_id = 64'd0;
         prev_offset = 64'd0;
         entries_todo = 31'd0;
         skip_todo = 31'd0;
         read_bytes = 4;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected result beat, kind", 64'(rsp_result_kind), 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report("result_kind", 64'(rsp_result_kind), 64'(want.kind));
               if (rsp_entry_id !== want.entry_id)
                  report("entry_id", rsp_entry_id, want.entry_id);
               if (rsp_entry_offset !== want.entry_offset)
                  report("entry_offset", rsp_entry_offset, want.entry_offset);
               if (rsp_error_code !== want.error_code)
                  report("error_code", 64'(rsp_error_code), 64'(want.error_code));
               if (rsp_last !== want.last)
                  report("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FILE_LENGTH:  cfg_file_length = csr_data[31:0];
               REG_MODULE_SIZE:  cfg_module_size = csr_data;
               REG_EXPECT_MAJOR: cfg_version[0] = csr_data[31:0];
               REG_EXPECT_MINOR: cfg_version[1] = csr_data[31:0];
               REG_EXPECT_PATCH: cfg_version[2] = csr_data[31:0];
               REG_EXPECT_BUILD: cfg_version[3] = csr_data[31:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_byte(req_data_byte);
      end
   end

endmodule

### verif/relocation_table_stream_decoder_tb.sv
// Testbench top for the relocation table stream decoder: builds one file with a
// random ending, drives it with random idling and gives the verdict.
// Depends on rtsd_pkg, the decoder and relocation_table_stream_decoder_checker.
module relocation_table_stream_decoder_tb;
   import rtsd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;

   // How the file ends: header faults first, then entry-level endings.
   typedef enum int {
      END_FORMAT, END_VERSION, END_NAMELEN, END_PTRSIZE, END_COUNT, END_MODSIZE,
      END_SHORT, END_ACCEPT, END_TRAILING, END_BAD_TYPE, END_OUTSIDE, END_OVERFLOW,
      END_TRUNC
   } ending_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [63:0] rsp_entry_id;
   logic [63:0] rsp_entry_offset;
   logic [3:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;
   int          fail_count;
   int          pending_count;

   bit          calm = 1'b0;
   int          rsp_hold;
   int          quiet_cycles;

   logic [7:0]  file_bytes [$];
   int          pause_at [$];
   logic [63:0] gen_id;
   logic [63:0] gen_offset;
   logic [31:0] length_value;

   relocation_table_stream_decoder dut (.*);

   relocation_table_stream_decoder_checker u_checker (.*);

   always #4 clock = ~clock;

   // Receiver stalls in bursts of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no beat on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Appends one byte to the end of the file.
   function automatic void append_byte(input logic [7:0] b);
      file_bytes = {file_bytes, b};
   endfunction

   function automatic void push_le(input logic [63:0] value, input int count);
      for (int k = 0; k < count; k++) append_byte(value[8*k +: 8]);
   endfunction

   function automatic int field_bytes(input logic [2:0] enc);
      case (enc)
         ENC_FULL:  return 8;
         ENC_PLUS1: return 0;
         ENC_ADD8, ENC_SUB8: return 1;
         ENC_ABS32: return 4;
         default:   return 2;
      endcase
   endfunction

   // Next value for the generator; 0 when the encoding would overflow.
   function automatic bit step_value(input logic [2:0] enc, input logic [63:0] prev,
                                     input logic [63:0] raw, output logic [63:0] value);
      value = raw;
      case (enc)
         ENC_PLUS1: begin
            value = prev + 64'd1;
            return prev != 64'hFFFF_FFFF_FFFF_FFFF;
         end
         ENC_ADD8, ENC_ADD16: begin
            value = prev + raw;
            return raw <= ~prev;
         end
         ENC_SUB8, ENC_SUB16: begin
            value = prev - raw;
            return raw <= prev;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic logic [63:0] random_raw(input int count);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (count < 8) v = v & ((64'd1 << (8 * count)) - 64'd1);
      return v;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Appends one entry that decodes cleanly, with offsets kept below 2^40.
   function automatic void add_good_entry();
      logic [2:0]  id_enc;
      logic [2:0]  off_enc;
      logic        scaled;
      logic [63:0] id_raw;
      logic [63:0] off_raw;
      logic [63:0] next_id;
      logic [63:0] next_off;
      logic [63:0] base;
      bit          ok;
      ok = 1'b0;
      while (!ok) begin
         id_enc = 3'($urandom);
         id_raw = random_raw(field_bytes(id_enc));
         ok = step_value(id_enc, gen_id, id_raw, next_id);
      end
      ok = 1'b0;
      while (!ok) begin
         off_enc = 3'($urandom);
         scaled = (gen_offset[2:0] == 3'd0) && ($urandom_range(0, 1) == 1);
         off_raw = random_raw(field_bytes(off_enc));
         if (off_enc == ENC_FULL) off_raw = off_raw & ((64'd1 << 37) - 64'd1);
         base = scaled ? (gen_offset >> 3) : gen_offset;
         ok = step_value(off_enc, base, off_raw, next_off) && (next_off < (64'd1 << 37));
      end
      append_byte({scaled, off_enc, 1'b0, id_enc});
      push_le(id_raw, field_bytes(id_enc));
      push_le(off_raw, field_bytes(off_enc));
      gen_id = next_id;
      gen_offset = scaled ? (next_off << 3) : next_off;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [63:0] module_size, input logic [31:0] vers [4]);
      write_reg(REG_FILE_LENGTH, 64'(length_value));
      write_reg(REG_MODULE_SIZE, module_size);
      write_reg(REG_EXPECT_MAJOR, {{32{vers[0][31]}}, vers[0]});
      write_reg(REG_EXPECT_MINOR, {{32{vers[1][31]}}, vers[1]});
      write_reg(REG_EXPECT_PATCH, {{32{vers[2][31]}}, vers[2]});
      write_reg(REG_EXPECT_BUILD, {{32{vers[3][31]}}, vers[3]});
      csr_valid <= 1'b0;
   endtask

   // Sends one byte beat, with an occasional idle burst in front of it.
   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      ending_type  ending;
      logic [31:0] vers [4];
      logic [31:0] sent_vers [4];
      logic [63:0] module_size;
      logic [31:0] name_len;
      logic [31:0] ptr_size;
      logic [31:0] count;
      int          entries;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'd0;
      csr_valid <= 1'b0;
      csr_index <= REG_FILE_LENGTH;
      csr_data <= 64'd0;

      // Build the whole file first, so that its length is known up front.
      ending = ending_type'($urandom_range(0, 19) < 7 ? $urandom_range(0, 6)
                                                       : $urandom_range(7, 12));
      foreach (vers[k]) vers[k] = random_word();
      sent_vers = vers;
      module_size = ($urandom_range(0, 2) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                : {1'b1, 31'($urandom), 32'($urandom)};
      entries = $urandom_range(180, 230);
      name_len = $urandom_range(0, 20);
      ptr_size = 32'd8;
      count = 32'(entries);
      if (ending == END_VERSION) sent_vers[$urandom_range(0, 3)] ^= 32'd1 << $urandom_range(0, 31);
      if (ending == END_NAMELEN) name_len = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 | $urandom
                                                                        : 32'h0010_0000;
      if (ending == END_PTRSIZE) ptr_size = ($urandom_range(0, 1) == 1) ? 32'd4 : $urandom | 32'h10;
      if (ending == END_COUNT) count = ($urandom_range(0, 1) == 1) ? 32'd0 : 32'h8000_0001;
      if (ending == END_MODSIZE) module_size = 64'd0;
      push_le((ending == END_FORMAT) ? 64'($urandom | 32'h100) : 64'd2, 4);
      foreach (sent_vers[k]) push_le(64'(sent_vers[k]), 4);
      push_le(64'(name_len), 4);
      if (name_len < 32'd64) repeat (name_len) append_byte(8'($urandom));
      push_le(64'(ptr_size), 4);
      push_le(64'(count), 4);
      gen_id = 64'd0;
      gen_offset = 64'd0;
      for (int n = 0; n < entries - 1; n++) begin
         if (n > 0 && n % 50 == 0) pause_at = {pause_at, file_bytes.size()};
         add_good_entry();
      end
      case (ending)
         END_BAD_TYPE: append_byte({4'($urandom), 1'b1, 3'($urandom)});
         END_OUTSIDE: begin
            append_byte({1'b0, ENC_FULL, 1'b0, ENC_ABS16});
            push_le(64'($urandom), 2);
            push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
         end
         END_OVERFLOW: begin
            append_byte({1'b1, ENC_FULL, 1'b0, ENC_FULL});
            push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
            push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
         end
         default: add_good_entry();
      endcase
      length_value = 32'(file_bytes.size());
      if (ending == END_TRAILING) length_value = 32'hFFFF_FFFF;
      if (ending == END_TRUNC) length_value = length_value - 32'd1;
      if (ending == END_SHORT) length_value = $urandom_range(1, 3);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_regs(module_size, vers);

      for (int idx = 0; idx < file_bytes.size(); idx++) begin
         calm = idx > (file_bytes.size() * 85) / 100;
         if (pause_at.size() > 0 && pause_at[0] == idx) begin
            void'(pause_at.pop_front());
            // Reprogram between entries once the block has drained.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
            repeat (10) @(posedge clock);
            foreach (vers[k]) vers[k] = random_word();
            program_regs({1'b1, 31'($urandom), 32'($urandom)}, vers);
         end
         send_byte(file_bytes[idx]);
      end
      // A few bytes after the final result, which the block drops.
      repeat (20) send_byte(8'($urandom));
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
